// ===== rtl/hb3su_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hb3su_pkg: shared types and codes
// Command kinds, status codes and the queue entry of the spin update engine.
// ---------------------------------------------------------------------------
package hb3su_pkg;

    localparam logic [2:0] ACT_UPDATE = 3'd0;
    localparam logic [2:0] ACT_WSPIN  = 3'd1;
    localparam logic [2:0] ACT_APPEND = 3'd2;
    localparam logic [2:0] ACT_WPROB  = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [2:0] K_NOP    = 3'd0;
    localparam logic [2:0] K_UPDATE = 3'd1;
    localparam logic [2:0] K_WSPIN  = 3'd2;
    localparam logic [2:0] K_APPEND = 3'd3;
    localparam logic [2:0] K_WPROB  = 3'd4;
    localparam logic [2:0] K_CLEAR  = 3'd5;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_SELF = 2'd2;

    localparam logic [16:0] PROB_ONE  = 17'd65536;
    localparam logic [16:0] PROB_HALF = 17'd32768;
    localparam int          FIELD_LIMIT = 32;

    typedef struct packed {
        logic [2:0]  kind;
        logic [13:0] node;
        logic [13:0] partner_a;
        logic [13:0] partner_b;
        logic        spin_value;
        logic [6:0]  table_index;
        logic [16:0] probability;
        logic [15:0] random_value;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/hb3su_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hb3su_in_if: item channel
// Valid/ready channel carrying one command item.
// ---------------------------------------------------------------------------
interface hb3su_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [13:0] node;
    logic [13:0] partner_a;
    logic [13:0] partner_b;
    logic        spin_value;
    logic signed [6:0] field_index;
    logic [16:0] probability_value;
    logic [15:0] random_value;

    modport source (output valid, action, node, partner_a, partner_b, spin_value,
                    field_index, probability_value, random_value, input ready);
    modport sink (input valid, action, node, partner_a, partner_b, spin_value,
                  field_index, probability_value, random_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/hb3su_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hb3su_out_if: result channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface hb3su_out_if;
    logic        valid;
    logic        ready;
    logic        new_spin;
    logic signed [6:0] local_field;
    logic [1:0]  status;

    modport source (output valid, new_spin, local_field, status, input ready);
    modport sink (input valid, new_spin, local_field, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/hb3su_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hb3su_cfg_if: configuration write channel
// Valid/ready channel carrying the mode register write data.
// ---------------------------------------------------------------------------
interface hb3su_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/heat_bath_three_spin_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item at a time in the execution side; the term walk reads one
// term and its two partner spins per cycle.
// Reset: synchronous; afterwards a clearing pass zeroes the degree counts while
// no item is taken.
// ---------------------------------------------------------------------------
// heat_bath_three_spin_update: heat-bath spin update engine
// Front intake queue, execution side with stores, mode register.
// ---------------------------------------------------------------------------
module heat_bath_three_spin_update #(
    parameter int NODES     = 16384,
    parameter int MAX_TERMS = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    hb3su_in_if.sink     i_item,
    hb3su_out_if.source  o_result,
    hb3su_cfg_if.sink    i_cfg
);

    logic            r_zero_temp;
    hb3su_pkg::t_cmd w_cmd;
    logic            w_cmd_valid;
    logic            w_cmd_pop;
    logic            w_clearing;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_temp <= 1'b0;
        end else if (i_cfg.valid) begin
            r_zero_temp <= i_cfg.data;
        end
    end

    hb3su_front #(.NODES(NODES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_hold      (w_clearing),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    hb3su_back #(.NODES(NODES), .MAX_TERMS(MAX_TERMS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_zero_temp (r_zero_temp),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_clearing  (w_clearing),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/hb3su_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hb3su_front: item intake
// Accepts items, classifies them and holds them in a two entry queue.
// ---------------------------------------------------------------------------
module hb3su_front #(
    parameter int NODES = 16384
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    hb3su_in_if.sink         i_item,
    input  wire              i_hold,
    output hb3su_pkg::t_cmd  o_cmd,
    output logic             o_cmd_valid,
    input  wire              i_cmd_pop
);

    hb3su_pkg::t_cmd r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    hb3su_pkg::t_cmd w_cmd;
    logic            w_push;
    logic            w_node_ok;
    logic            w_tidx_ok;

    assign i_item.ready = (r_cnt != 2'd2) && !i_hold;
    assign w_push       = i_item.valid && i_item.ready;
    assign w_node_ok    = 32'(i_item.node) < NODES;
    assign w_tidx_ok    = (i_item.field_index >= -7'sd32) && (i_item.field_index <= 7'sd32);

    always_comb begin
        w_cmd.node         = i_item.node;
        w_cmd.partner_a    = i_item.partner_a;
        w_cmd.partner_b    = i_item.partner_b;
        w_cmd.spin_value   = i_item.spin_value;
        w_cmd.table_index  = 7'(i_item.field_index + 7'sd32);
        w_cmd.probability  = (i_item.probability_value > hb3su_pkg::PROB_ONE) ?
                             hb3su_pkg::PROB_ONE : i_item.probability_value;
        w_cmd.random_value = i_item.random_value;
        case (i_item.action)
            hb3su_pkg::ACT_UPDATE: w_cmd.kind = w_node_ok ? hb3su_pkg::K_UPDATE
                                                          : hb3su_pkg::K_NOP;
            hb3su_pkg::ACT_WSPIN:  w_cmd.kind = w_node_ok ? hb3su_pkg::K_WSPIN
                                                          : hb3su_pkg::K_NOP;
            hb3su_pkg::ACT_APPEND: w_cmd.kind = w_node_ok ? hb3su_pkg::K_APPEND
                                                          : hb3su_pkg::K_NOP;
            hb3su_pkg::ACT_WPROB:  w_cmd.kind = w_tidx_ok ? hb3su_pkg::K_WPROB
                                                          : hb3su_pkg::K_NOP;
            hb3su_pkg::ACT_CLEAR:  w_cmd.kind = w_node_ok ? hb3su_pkg::K_CLEAR
                                                          : hb3su_pkg::K_NOP;
            default:               w_cmd.kind = hb3su_pkg::K_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end

    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = r_cnt != 2'd0;

endmodule
`default_nettype wire

// ===== rtl/hb3su_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hb3su_back: command execution
// Holds the spin, degree, term and probability stores, walks a node's
// terms to form the local field and registers the result.
// ---------------------------------------------------------------------------
module hb3su_back #(
    parameter int NODES     = 16384,
    parameter int MAX_TERMS = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_zero_temp,
    input  hb3su_pkg::t_cmd  i_cmd,
    input  wire              i_cmd_valid,
    output logic             o_cmd_pop,
    output logic             o_clearing,
    hb3su_out_if.source      o_result
);

    localparam int NW  = $clog2(NODES);
    localparam int CW  = $clog2(MAX_TERMS + 1);
    localparam int TAW = $clog2(NODES * MAX_TERMS);
    localparam int HW  = $clog2(MAX_TERMS + 1) + 2;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;

    logic            m_spin [NODES];
    logic [CW-1:0]   m_cnt  [NODES];
    logic [27:0]     m_term [NODES * MAX_TERMS];
    logic [16:0]     m_prob [2 * hb3su_pkg::FIELD_LIMIT + 1];

    logic [2:0]      r_state, n_state;
    logic [NW-1:0]   r_clr;
    hb3su_pkg::t_cmd r_cmd;
    logic [TAW-1:0]  r_base;
    logic [CW-1:0]   r_n;
    logic [CW-1:0]   r_k;
    logic            r_t_v;
    logic            r_s_v;
    logic            r_pa_oor;
    logic            r_pb_oor;
    logic signed [HW-1:0] r_h;
    logic            r_spin_a;
    logic            r_spin_b;
    logic [CW-1:0]   r_cnt_q;
    logic [27:0]     r_term_q;
    logic [16:0]     r_prob_q;
    logic            r_out_valid;
    logic            r_out_spin;
    logic [6:0]      r_out_field;
    logic [1:0]      r_out_status;

    logic [NW-1:0]   w_spin_ra;
    logic [NW-1:0]   w_spin_rb;
    logic            w_spin_we;
    logic [NW-1:0]   w_spin_wa;
    logic            w_spin_wd;
    logic            w_cnt_we;
    logic [NW-1:0]   w_cnt_wa;
    logic [CW-1:0]   w_cnt_wd;
    logic            w_term_we;
    logic signed [31:0] w_h32;
    logic [6:0]      w_tab_ra;
    logic [6:0]      w_field_sat;
    logic [16:0]     w_prob;
    logic            w_new_spin;
    logic            w_full;
    logic            w_self;
    logic            w_sa;
    logic            w_sb;

    assign o_clearing = r_state == ST_CLR;
    assign o_cmd_pop  = (r_state == ST_IDLE) && i_cmd_valid &&
                        (!r_out_valid || o_result.ready);

    assign w_h32 = 32'(r_h);
    assign w_tab_ra = (w_h32 > 32'sd32) ? 7'd64 :
                      (w_h32 < -32'sd32) ? 7'd0 : 7'(w_h32 + 32'sd32);
    assign w_field_sat = (w_h32 > 32'sd63) ? 7'd63 :
                         (w_h32 < -32'sd64) ? 7'h40 : 7'(w_h32);
    assign w_prob = i_zero_temp ? ((w_h32 > 0) ? hb3su_pkg::PROB_ONE :
                                   (w_h32 == 0) ? hb3su_pkg::PROB_HALF : 17'd0)
                                : r_prob_q;
    assign w_new_spin = {1'b0, r_cmd.random_value} <= w_prob;
    assign w_self = (r_cmd.node == r_cmd.partner_a) || (r_cmd.node == r_cmd.partner_b);
    assign w_full = 32'(r_cnt_q) >= MAX_TERMS;
    assign w_sa   = r_spin_a && !r_pa_oor;
    assign w_sb   = r_spin_b && !r_pb_oor;

    assign w_spin_ra = (r_state == ST_IDLE) ? NW'(32'(i_cmd.node)) : NW'(32'(r_term_q[13:0]));
    assign w_spin_rb = NW'(32'(r_term_q[27:14]));

    always_comb begin
        w_spin_we = 1'b0;
        w_spin_wa = NW'(32'(i_cmd.node));
        w_spin_wd = i_cmd.spin_value;
        w_cnt_we  = 1'b0;
        w_cnt_wa  = NW'(32'(r_cmd.node));
        w_cnt_wd  = '0;
        w_term_we = 1'b0;
        n_state   = r_state;
        case (r_state)
            ST_CLR: begin
                w_cnt_we = 1'b1;
                w_cnt_wa = r_clr;
                if (32'(r_clr) == NODES - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_cmd_pop) begin
                    w_spin_we = i_cmd.kind == hb3su_pkg::K_WSPIN;
                    if ((i_cmd.kind == hb3su_pkg::K_UPDATE) ||
                        (i_cmd.kind == hb3su_pkg::K_APPEND) ||
                        (i_cmd.kind == hb3su_pkg::K_CLEAR)) begin
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                if (r_cmd.kind == hb3su_pkg::K_UPDATE) begin
                    n_state = ST_WALK;
                end else begin
                    n_state = ST_IDLE;
                    if (r_cmd.kind == hb3su_pkg::K_CLEAR) begin
                        w_cnt_we = 1'b1;
                    end else if (!w_self && !w_full) begin
                        w_cnt_we  = 1'b1;
                        w_cnt_wd  = r_cnt_q + CW'(1);
                        w_term_we = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                if ((r_k == r_n) && !r_t_v && !r_s_v) begin
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                w_spin_we = 1'b1;
                w_spin_wa = NW'(32'(r_cmd.node));
                w_spin_wd = w_new_spin;
                n_state   = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_spin_we) begin
            m_spin[w_spin_wa] <= w_spin_wd;
        end
        r_spin_a <= m_spin[w_spin_ra];
        r_spin_b <= m_spin[w_spin_rb];
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            m_cnt[w_cnt_wa] <= w_cnt_wd;
        end
        r_cnt_q <= m_cnt[NW'(32'(i_cmd.node))];
    end

    always_ff @(posedge i_clk) begin
        if (w_term_we) begin
            m_term[r_base + TAW'(r_cnt_q)] <= {r_cmd.partner_b, r_cmd.partner_a};
        end
        r_term_q <= m_term[r_base + TAW'(r_k)];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.kind == hb3su_pkg::K_WPROB)) begin
            m_prob[i_cmd.table_index] <= i_cmd.probability;
        end
        r_prob_q <= m_prob[w_tab_ra];
    end

    // term walk: address, term data, spin data
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd  <= i_cmd;
            r_base <= TAW'(32'(i_cmd.node) * MAX_TERMS);
        end
        r_pa_oor <= 32'(r_term_q[13:0]) >= NODES;
        r_pb_oor <= 32'(r_term_q[27:14]) >= NODES;
        if (r_state == ST_LOOK) begin
            r_n <= r_cnt_q;
            r_k <= '0;
            r_h <= '0;
        end else if (r_state == ST_WALK) begin
            if (r_k != r_n) begin
                r_k <= r_k + CW'(1);
            end
            if (r_s_v) begin
                r_h <= (w_sa == w_sb) ? r_h + HW'(1) : r_h - HW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_t_v       <= 1'b0;
            r_s_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                r_clr <= r_clr + NW'(1);
            end
            r_t_v <= (r_state == ST_WALK) && (r_k != r_n);
            r_s_v <= (r_state == ST_WALK) && r_t_v;
            if (o_cmd_pop && (n_state == ST_IDLE)) begin
                r_out_valid  <= 1'b1;
                r_out_spin   <= (i_cmd.kind == hb3su_pkg::K_WSPIN) && i_cmd.spin_value;
                r_out_field  <= '0;
                r_out_status <= hb3su_pkg::STAT_OK;
            end else if ((r_state == ST_LOOK) && (r_cmd.kind != hb3su_pkg::K_UPDATE)) begin
                r_out_valid  <= 1'b1;
                r_out_spin   <= r_spin_a;
                r_out_field  <= '0;
                r_out_status <= (r_cmd.kind == hb3su_pkg::K_CLEAR) ? hb3su_pkg::STAT_OK :
                                w_self ? hb3su_pkg::STAT_SELF :
                                w_full ? hb3su_pkg::STAT_FULL : hb3su_pkg::STAT_OK;
            end else if (r_state == ST_DEC) begin
                r_out_valid  <= 1'b1;
                r_out_spin   <= w_new_spin;
                r_out_field  <= w_field_sat;
                r_out_status <= hb3su_pkg::STAT_OK;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.new_spin    = r_out_spin;
    assign o_result.local_field = r_out_field;
    assign o_result.status      = r_out_status;

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !o_cmd_pop) else $error("pop during clearing pass");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_k <= r_n)) else $error("term walk overran");
    a_spin_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v |-> $past(r_t_v)) else $error("spin stage without term stage");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> r_out_valid) else $error("result dropped");

endmodule
`default_nettype wire

// ===== tb/heat_bath_three_spin_update_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heat_bath_three_spin_update_tb: self-checking bench for the spin update engine
// Drives loads, appends, clears and updates with random gaps and receiver
// stalls. Predicts every result from a local copy of the stores and the mode
// bit, and compares each result transfer in order.
// ---------------------------------------------------------------------------
module heat_bath_three_spin_update_tb;

    localparam int NUM_NODES = 16384;
    localparam int TERM_MAX  = 32;

    typedef struct {
        logic [2:0]        action;
        logic [13:0]       node;
        logic [13:0]       partner_a;
        logic [13:0]       partner_b;
        logic              spin_value;
        logic signed [6:0] field_index;
        logic [16:0]       probability_value;
        logic [15:0]       random_value;
    } t_item;

    typedef struct {
        logic              new_spin;
        logic signed [6:0] local_field;
        logic [1:0]        status;
    } t_spin_result;

    logic clk;
    logic rst_n;

    hb3su_in_if  item_if();
    hb3su_out_if res_if();
    hb3su_cfg_if cfg_if();

    heat_bath_three_spin_update DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // predictor state
    bit          spin_mem [NUM_NODES];
    int unsigned degree [NUM_NODES];
    logic [27:0] term_mem [int];
    logic [16:0] prob_tab [65];
    bit          zero_temp;

    t_spin_result expected_results [$];
    int          pool [$];
    bit          in_pool [NUM_NODES];
    int          mismatches;
    int          rx_hold;
    int          burst_left;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #40ms;
        $display("heat_bath_three_spin_update_tb: FAIL");
        $finish;
    end

    // receiver: long hold-off first, else a stall pattern that changes over time
    initial begin : receiver
        int rx_mode;
        int rx_cycles;
        rx_mode = 0;
        rx_cycles = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_cycles == 0) begin
                rx_mode = $urandom_range(2);
                rx_cycles = $urandom_range(300, 50);
            end
            rx_cycles--;
            if (rx_hold > 0) begin
                rx_hold--;
                res_if.ready = 1'b0;
            end else begin
                case (rx_mode)
                    0: res_if.ready = 1'b1;
                    1: res_if.ready = ($urandom_range(99) < 70);
                    default: res_if.ready = ($urandom_range(99) < 25);
                endcase
            end
        end
    end

    function automatic t_spin_result predict_spin_result(t_item it);
        t_spin_result r;
        int h;
        int unsigned p;
        int idx;
        logic [27:0] t;
        r = '{1'b0, 7'sd0, hb3su_pkg::STAT_OK};
        case (it.action)
            hb3su_pkg::ACT_UPDATE: begin
                h = 0;
                for (int k = 0; k < degree[it.node]; k++) begin
                    t = term_mem[it.node * TERM_MAX + k];
                    h += ((spin_mem[t[13:0]] ? 1 : -1) * (spin_mem[t[27:14]] ? 1 : -1));
                end
                if (zero_temp) begin
                    p = (h > 0) ? 32'(hb3su_pkg::PROB_ONE) :
                        ((h == 0) ? 32'(hb3su_pkg::PROB_HALF) : 0);
                end else begin
                    idx = h;
                    if (idx > hb3su_pkg::FIELD_LIMIT) idx = hb3su_pkg::FIELD_LIMIT;
                    if (idx < -hb3su_pkg::FIELD_LIMIT) idx = -hb3su_pkg::FIELD_LIMIT;
                    p = 32'(prob_tab[idx + hb3su_pkg::FIELD_LIMIT]);
                end
                r.new_spin = (it.random_value <= p);
                spin_mem[it.node] = r.new_spin;
                r.local_field = 7'(h);
            end
            hb3su_pkg::ACT_WSPIN: begin
                spin_mem[it.node] = it.spin_value;
                r.new_spin = it.spin_value;
            end
            hb3su_pkg::ACT_APPEND: begin
                r.new_spin = spin_mem[it.node];
                if (it.node == it.partner_a || it.node == it.partner_b) begin
                    r.status = hb3su_pkg::STAT_SELF;
                end else if (degree[it.node] >= TERM_MAX) begin
                    r.status = hb3su_pkg::STAT_FULL;
                end else begin
                    term_mem[it.node * TERM_MAX + degree[it.node]] = {it.partner_b, it.partner_a};
                    degree[it.node]++;
                end
            end
            hb3su_pkg::ACT_WPROB: begin
                if (it.field_index >= -hb3su_pkg::FIELD_LIMIT &&
                    it.field_index <= hb3su_pkg::FIELD_LIMIT) begin
                    prob_tab[it.field_index + hb3su_pkg::FIELD_LIMIT] =
                        (it.probability_value > hb3su_pkg::PROB_ONE) ? hb3su_pkg::PROB_ONE
                                                                    : it.probability_value;
                end
            end
            hb3su_pkg::ACT_CLEAR: begin
                degree[it.node] = 0;
                r.new_spin = spin_mem[it.node];
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk) begin
        t_spin_result e;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                e = expected_results.pop_front();
                if (res_if.new_spin !== e.new_spin || res_if.local_field !== e.local_field ||
                    res_if.status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp spin %0d field %0d status %0d, got %0d %0d %0d",
                                 e.new_spin, e.local_field, e.status,
                                 res_if.new_spin, res_if.local_field, res_if.status);
                end
            end
        end
    end

    task automatic send_item(t_item it);
        @(negedge clk);
        item_if.valid             = 1'b1;
        item_if.action            = it.action;
        item_if.node              = it.node;
        item_if.partner_a         = it.partner_a;
        item_if.partner_b         = it.partner_b;
        item_if.spin_value        = it.spin_value;
        item_if.field_index       = it.field_index;
        item_if.probability_value = it.probability_value;
        item_if.random_value      = it.random_value;
        do @(posedge clk); while (!item_if.ready);
        expected_results.push_back(predict_spin_result(it));
        if (it.action == hb3su_pkg::ACT_WSPIN && !in_pool[it.node]) begin
            in_pool[it.node] = 1'b1;
            pool.push_back(int'(it.node));
        end
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge clk);
            item_if.valid = 1'b0;
        end
    endtask

    // bursts of random length with random gaps between them
    task automatic send_paced(t_item it);
        if (burst_left == 0) begin
            if ($urandom_range(3) != 0) idle_cycles($urandom_range(8, 1));
            burst_left = $urandom_range(20, 1);
        end
        burst_left--;
        send_item(it);
    endtask

    function automatic t_item noise_item();
        t_item it;
        it.action            = 3'($urandom_range(7));
        it.node              = 14'($urandom);
        it.partner_a         = 14'($urandom);
        it.partner_b         = 14'($urandom);
        it.spin_value        = 1'($urandom);
        it.field_index       = 7'($urandom);
        it.probability_value = 17'($urandom);
        it.random_value      = 16'($urandom);
        return it;
    endfunction

    function automatic int pick_node();
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    function automatic t_item make_item(logic [2:0] act, int node);
        t_item it;
        it = noise_item();
        it.action = act;
        it.node   = 14'(node);
        return it;
    endfunction

    function automatic t_item make_append(int node, int pa, int pb);
        t_item it;
        it = make_item(hb3su_pkg::ACT_APPEND, node);
        it.partner_a = 14'(pa);
        it.partner_b = 14'(pb);
        return it;
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        item_if.valid = 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_mode(bit value);
        wait_drained();
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        do @(posedge clk); while (!cfg_if.ready);
        zero_temp = value;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic test_load_stores();
        t_item it;
        int seeds [$] = '{0, 16383, 5461, 10922, 1, 2, 3, 4, 5, 6, 7, 8};
        foreach (seeds[i]) begin
            it = make_item(hb3su_pkg::ACT_WSPIN, seeds[i]);
            send_item(it);
        end
        for (int f = -hb3su_pkg::FIELD_LIMIT; f <= hb3su_pkg::FIELD_LIMIT; f++) begin
            it = make_item(hb3su_pkg::ACT_WPROB, 0);
            it.field_index = 7'(f);
            if (f == -hb3su_pkg::FIELD_LIMIT)     it.probability_value = 17'd0;
            else if (f == hb3su_pkg::FIELD_LIMIT) it.probability_value = 17'h1FFFF;
            else if (f == 0)                      it.probability_value = hb3su_pkg::PROB_ONE;
            else it.probability_value = 17'($urandom_range(70000));
            send_item(it);
        end
        it = make_item(hb3su_pkg::ACT_WPROB, 0);
        it.field_index = -7'sd64;
        send_item(it);
        it.field_index = 7'sd63;
        send_item(it);
        it.field_index = 7'sd33;
        send_item(it);
    endtask

    task automatic test_append_checks();
        send_item(make_append(1, 1, 2));
        send_item(make_append(1, 3, 1));
        send_item(make_append(1, 1, 1));
        for (int k = 0; k < TERM_MAX; k++)
            send_item(make_append(1, 16383, (k % 2) ? 0 : 5461));
        send_item(make_append(1, 2, 3));
        send_item(make_append(1, 1, 4));
    endtask

    task automatic test_update_extremes();
        t_item it;
        it = make_item(hb3su_pkg::ACT_UPDATE, 1);
        it.random_value = 16'd0;
        send_item(it);
        it.random_value = 16'hFFFF;
        send_item(it);
        send_item(make_item(hb3su_pkg::ACT_UPDATE, 2));
        send_item(make_item(hb3su_pkg::ACT_CLEAR, 1));
        send_item(make_item(hb3su_pkg::ACT_UPDATE, 1));
        for (int a = 5; a < 8; a++) send_item(make_item(a[2:0], $urandom_range(16383)));
    endtask

    task automatic test_zero_temperature();
        t_item it;
        write_mode(1'b1);
        send_item(make_append(2, 3, 4));
        send_item(make_append(6, 7, 8));
        send_item(make_append(6, 3, 4));
        for (int n = 2; n <= 6; n += 4) begin
            it = make_item(hb3su_pkg::ACT_UPDATE, n);
            it.random_value = 16'hFFFF;
            send_item(it);
            it.random_value = 16'h8000;
            send_item(it);
            it.random_value = 16'h8001;
            send_item(it);
        end
        write_mode(1'b0);
    endtask

    task automatic send_random(int count);
        t_item it;
        int sel;
        int n;
        repeat (count) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
                it = make_item(hb3su_pkg::ACT_UPDATE, pick_node());
            end else if (sel < 52) begin
                it = make_item(hb3su_pkg::ACT_WSPIN,
                               ($urandom_range(3) == 0) ? $urandom_range(16383) : pick_node());
            end else if (sel < 84) begin
                n = ($urandom_range(9) < 6) ? pool[$urandom_range(7)] : pick_node();
                it = make_append(n, pick_node(), pick_node());
                if ($urandom_range(9) == 0) begin
                    if ($urandom_range(1)) it.partner_a = 14'(n);
                    else it.partner_b = 14'(n);
                end
            end else if (sel < 90) begin
                it = make_item(hb3su_pkg::ACT_WPROB, 0);
            end else if (sel < 95) begin
                it = make_item(hb3su_pkg::ACT_CLEAR, pick_node());
            end else begin
                it = make_item(3'($urandom_range(7, 5)), $urandom_range(16383));
            end
            send_paced(it);
        end
    endtask

    task automatic test_backpressure();
        rx_hold = 400;
        send_random(40);
    endtask

    initial begin
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.action = hb3su_pkg::ACT_UPDATE;
        item_if.node = '0;
        item_if.partner_a = '0;
        item_if.partner_b = '0;
        item_if.spin_value = 1'b0;
        item_if.field_index = '0;
        item_if.probability_value = '0;
        item_if.random_value = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = 1'b0;
        mismatches = 0;
        rx_hold = 0;
        burst_left = 0;
        zero_temp = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_mode(1'b0);
        test_load_stores();
        test_append_checks();
        test_update_extremes();
        test_zero_temperature();
        send_random(400);
        test_backpressure();
        write_mode(1'b1);
        send_random(400);
        write_mode(1'b0);
        send_random(400);
        write_mode(1'b1);
        send_random(400);

        wait_drained();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("heat_bath_three_spin_update_tb: PASS");
        end else begin
            $display("heat_bath_three_spin_update_tb: FAIL");
        end
        $finish;
    end
endmodule
